>>> src/lph_pkg.sv
// Package for the linear-probe hash table: sizes, codes, job types and hash functions.
// No dependencies; used by every other file of the block.
package lph_pkg;

    localparam int SLOTS = 1024;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int KEY_W = 32;
    localparam int PAY_W = 64;
    localparam int DIV_BITS = 4;
    localparam int DIV_STEPS = KEY_W / DIV_BITS;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] REG_MAX_FILL   = 2'd1;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic [IDX_W-1:0] home;
    } lph_job_t;

    typedef struct packed {
        logic clearing;
    } lph_back_status_t;

    function automatic logic [KEY_W-1:0] mix_lo(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] v;
        v = k;
        v = v + (v << 12);
        v = v ^ (v >> 22);
        v = v + (v << 4);
        v = v ^ (v >> 9);
        return v;
    endfunction

    function automatic logic [KEY_W-1:0] mix_hi(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] v;
        v = k;
        v = v + (v << 10);
        v = v ^ (v >> 2);
        v = v + (v << 7);
        v = v ^ (v >> 12);
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] div_step(input logic [CNT_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] sh;
        sh = {rem[CNT_W-2:0], bit_in};
        if (sh >= n)
        begin
            sh = sh - n;
        end
        return sh;
    endfunction

endpackage

>>> src/lph_if.sv
// Channel interfaces for the hash table: command words in, result words out.
// Depends on lph_pkg.
interface lph_cmd_if
    import lph_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;

    modport source (output valid, output opcode, output key, output payload, input ready);
    modport sink (input valid, input opcode, input key, input payload, output ready);
endinterface

interface lph_res_if
    import lph_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [IDX_W-1:0] slot;
    logic [PAY_W-1:0] read_data;
    logic [CNT_W-1:0] live_count;

    modport source (output valid, output status, output slot, output read_data,
                    output live_count, input ready);
    modport sink (input valid, input status, input slot, input read_data,
                  input live_count, output ready);
endinterface

>>> src/linear_probe_hash_table.sv
// Top level of the linear-probe hash table: configuration registers, front end,
// job queue and probe engine. Depends on lph_pkg, lph_if and the lph_* modules.
//
// Usage: command words (opcode, key, payload) enter on cmd; one result word
// (status, slot, read_data, live_count) leaves on res for each command, in order.
// Configuration writes (cfg_we, cfg_index, cfg_data) set table_size and max_fill.
// Flow: the front end finishes the hash and reduces it modulo the table size (4 quotient
// bits a cycle), then pushes the job into the queue, and the probe engine pops it; each
// probe reads the slot memory and checks the word, a lookup that finds its key then reads
// the payload, and the result goes into the result register.
// The front end takes one command at a time and does not take the next until the job
// is pushed; the two-entry queue lets it hash the next command while the probe engine
// works on the previous one.
// After reset the slot marks are cleared in a pass over all 1024 slots, one slot a
// cycle; cmd.ready stays low during it. Configuration writes are taken at any time.
// While res is stalled the result word holds and the probe engine waits; the
// front end keeps filling the queue until it is full.
module linear_probe_hash_table
    import lph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    lph_cmd_if.sink          cmd,
    lph_res_if.source        res,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CNT_W-1:0] cfg_data
);
    logic [CNT_W-1:0] table_size_reg;
    logic [CNT_W-1:0] max_fill_reg;
    logic [CNT_W-1:0] size;
    logic             push, q_full, q_valid, pop;
    lph_job_t         push_job, q_head;
    lph_back_status_t back_status;

    always_comb
    begin
        if (table_size_reg > CNT_W'(SLOTS))
        begin
            size = CNT_W'(SLOTS);
        end
        else if (table_size_reg == '0)
        begin
            size = CNT_W'(1);
        end
        else
        begin
            size = table_size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= CNT_W'(1021);
            max_fill_reg <= CNT_W'(765);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TABLE_SIZE: table_size_reg <= cfg_data;
                REG_MAX_FILL: max_fill_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    lph_front u_front (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .size(size), .back_status(back_status),
        .push(push), .push_job(push_job), .q_full(q_full)
    );

    lph_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .full(q_full),
        .pop(pop), .not_empty(q_valid), .head(q_head)
    );

    lph_back u_back (
        .clk(clk), .rst_n(rst_n), .size(size), .max_fill(max_fill_reg),
        .q_valid(q_valid), .q_head(q_head), .pop(pop), .back_status(back_status),
        .res(res)
    );

endmodule

>>> src/lph_front.sv
// Front end: accepts command words, hashes the key and reduces it modulo the table size.
// Depends on lph_pkg and lph_if.
module lph_front
    import lph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    lph_cmd_if.sink          cmd,
    input  logic [CNT_W-1:0] size,
    input  lph_back_status_t back_status,
    output logic             push,
    output lph_job_t         push_job,
    input  logic             q_full
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MIX  = 2'd1;
    localparam logic [1:0] F_DIV  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [KEY_W-1:0]  h_reg, h_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PAY_W-1:0]  pay_reg;
    logic              take;

    assign cmd.ready = (state_reg == F_IDLE) && !back_status.clearing;
    assign take = cmd.valid && cmd.ready;
    assign push = (state_reg == F_PUSH) && !q_full;
    assign push_job = '{opcode: op_reg, key: key_reg, payload: pay_reg,
                        home: rem_reg[IDX_W-1:0]};

    always_comb
    begin
        logic [CNT_W-1:0] r;
        r = rem_reg;
        state_next = state_reg;
        step_next = step_reg;
        h_next = h_reg;
        rem_next = rem_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    h_next = mix_lo(cmd.key);
                    state_next = F_MIX;
                end
            end
            F_MIX:
            begin
                h_next = mix_hi(h_reg);
                rem_next = '0;
                step_next = '0;
                state_next = F_DIV;
            end
            F_DIV:
            begin
                for (int b = 0; b < DIV_BITS; b++)
                begin
                    r = div_step(r, h_reg[KEY_W-1-b], size);
                end
                rem_next = r;
                h_next = h_reg << DIV_BITS;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        rem_reg <= rem_next;
        if (take)
        begin
            op_reg <= cmd.opcode;
            key_reg <= cmd.key;
            pay_reg <= cmd.payload;
        end
    end

endmodule

>>> src/lph_queue.sv
// Two-entry job queue between the front end and the probe engine.
// Depends on lph_pkg.
module lph_queue
    import lph_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lph_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output lph_job_t head
);
    lph_job_t   entry_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head = entry_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_job;
        end
    end

endmodule

>>> src/lph_back.sv
// Probe engine: slot memories, linear probing, live count and the result register.
// Depends on lph_pkg and lph_if.
module lph_back
    import lph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] size,
    input  logic [CNT_W-1:0] max_fill,
    input  logic             q_valid,
    input  lph_job_t         q_head,
    output logic             pop,
    output lph_back_status_t back_status,
    lph_res_if.source        res
);
    localparam logic [2:0] B_CLEAR = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_PROBE = 3'd2;
    localparam logic [2:0] B_CHECK = 3'd3;
    localparam logic [2:0] B_PREAD = 3'd4;
    localparam logic [2:0] B_RES   = 3'd5;

    localparam int WORD_W = KEY_W + 2;

    logic [WORD_W-1:0] key_mem [SLOTS];
    logic [PAY_W-1:0]  pay_mem [SLOTS];
    logic [WORD_W-1:0] key_rd_reg;
    logic [PAY_W-1:0]  pay_rd_reg;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] s_reg, s_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [PAY_W-1:0] pay_reg;
    logic [2:0]       st_reg, st_next;
    logic [IDX_W-1:0] sl_reg, sl_next;
    logic             dsel_reg, dsel_next;

    logic              out_valid_reg;
    logic [2:0]        out_st_reg;
    logic [IDX_W-1:0]  out_sl_reg;
    logic [PAY_W-1:0]  out_data_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic              load;

    logic              kw_en, pw_en;
    logic [IDX_W-1:0]  kw_addr;
    logic [WORD_W-1:0] kw_data;

    logic              filled, deleted, last;
    logic [CNT_W-1:0]  s_inc;

    assign filled = key_rd_reg[WORD_W-1];
    assign deleted = key_rd_reg[WORD_W-2];
    assign s_inc = {1'b0, s_reg} + 1'b1;
    assign last = (i_reg + 1'b1) >= size;
    assign back_status = '{clearing: state_reg == B_CLEAR};
    assign pop = (state_reg == B_IDLE) && q_valid;
    assign load = (state_reg == B_RES) && (!out_valid_reg || res.ready);

    assign res.valid = out_valid_reg;
    assign res.status = out_st_reg;
    assign res.slot = out_sl_reg;
    assign res.read_data = out_data_reg;
    assign res.live_count = out_cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        s_next = s_reg;
        i_next = i_reg;
        count_next = count_reg;
        st_next = st_reg;
        sl_next = sl_reg;
        dsel_next = dsel_reg;
        kw_en = 1'b0;
        pw_en = 1'b0;
        kw_addr = s_reg;
        kw_data = {1'b1, 1'b0, key_reg};
        case (state_reg)
            B_CLEAR:
            begin
                kw_en = 1'b1;
                kw_addr = clr_reg;
                kw_data = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    s_next = q_head.home;
                    i_next = '0;
                    sl_next = '0;
                    dsel_next = 1'b0;
                    st_next = ST_NOT_FOUND;
                    case (q_head.opcode)
                        OP_INSERT:
                        begin
                            if (count_reg >= max_fill)
                            begin
                                st_next = ST_FULL;
                                state_next = B_RES;
                            end
                            else
                            begin
                                state_next = B_PROBE;
                            end
                        end
                        OP_LOOKUP, OP_DELETE: state_next = B_PROBE;
                        default: state_next = B_RES;
                    endcase
                end
            end
            B_PROBE:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                s_next = (s_inc >= size) ? '0 : s_inc[IDX_W-1:0];
                i_next = i_reg + 1'b1;
                state_next = B_PROBE;
                if (op_reg == OP_INSERT)
                begin
                    if (!filled || deleted)
                    begin
                        kw_en = 1'b1;
                        pw_en = 1'b1;
                        count_next = count_reg + 1'b1;
                        st_next = ST_INSERTED;
                        sl_next = s_reg;
                        s_next = s_reg;
                        state_next = B_RES;
                    end
                    else if (last)
                    begin
                        st_next = ST_FULL;
                        state_next = B_RES;
                    end
                end
                else
                begin
                    if (!filled)
                    begin
                        state_next = B_RES;
                    end
                    else if (key_rd_reg[KEY_W-1:0] == key_reg)
                    begin
                        s_next = s_reg;
                        state_next = B_RES;
                        if (!deleted)
                        begin
                            sl_next = s_reg;
                            if (op_reg == OP_LOOKUP)
                            begin
                                st_next = ST_FOUND;
                                dsel_next = 1'b1;
                                state_next = B_PREAD;
                            end
                            else
                            begin
                                st_next = ST_DELETED;
                                kw_en = 1'b1;
                                kw_data = {1'b1, 1'b1, key_reg};
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                    end
                    else if (last)
                    begin
                        state_next = B_RES;
                    end
                end
            end
            B_PREAD:
            begin
                state_next = B_RES;
            end
            B_RES:
            begin
                if (load)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            count_reg <= count_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        i_reg <= i_next;
        st_reg <= st_next;
        sl_reg <= sl_next;
        dsel_reg <= dsel_next;
        if (pop)
        begin
            op_reg <= q_head.opcode;
            key_reg <= q_head.key;
            pay_reg <= q_head.payload;
        end
        if (load)
        begin
            out_st_reg <= st_reg;
            out_sl_reg <= sl_reg;
            out_data_reg <= dsel_reg ? pay_rd_reg : '0;
            out_cnt_reg <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (kw_en)
        begin
            key_mem[kw_addr] <= kw_data;
        end
        key_rd_reg <= key_mem[s_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            pay_mem[s_reg] <= pay_reg;
        end
        pay_rd_reg <= pay_mem[s_reg];
    end

endmodule

>>> src/lph_checker.sv
// Port checker for the hash table's result channel, bound to the top level.
// Depends on lph_pkg.
module lph_checker
    import lph_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input logic [2:0]       res_status,
    input logic [IDX_W-1:0] res_slot,
    input logic [PAY_W-1:0] res_read_data,
    input logic [CNT_W-1:0] res_live_count
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_slot))
        else $error("result word changed while stalled");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_NOT_FOUND || res_status == ST_FULL) |-> res_slot == '0)
        else $error("slot not zero on a miss or full");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_FOUND |-> res_read_data == '0)
        else $error("read data set without a find");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_INSERTED |-> res_live_count != '0)
        else $error("zero live count after an insert");

endmodule

bind linear_probe_hash_table lph_checker u_chk (
    .clk(clk), .rst_n(rst_n), .res_valid(res.valid), .res_ready(res.ready),
    .res_status(res.status), .res_slot(res.slot), .res_read_data(res.read_data),
    .res_live_count(res.live_count)
);
